### rtl/aging_duplicate_filter_macros.svh
// Assertion macros used by the aging duplicate filter top level.
`ifndef AGING_DUPLICATE_FILTER_MACROS_SVH
`define AGING_DUPLICATE_FILTER_MACROS_SVH

// Same-cycle implication, sampled on the block clock, quiet during reset.
`define ADF_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on the block clock, quiet during reset.
`define ADF_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/adf_pkg.sv
// Types and constants shared by the aging duplicate filter modules.
package adf_pkg;

  localparam int unsigned KeyW   = 16;
  localparam int unsigned StampW = 16;
  localparam int unsigned OutCntW = 5;
  localparam logic [15:0] MaxAgeReset = 16'd6;

  typedef enum logic [1:0] {
    OP_TICK         = 2'd0,
    OP_CHECK_INSERT = 2'd1,
    OP_INSERT       = 2'd2,
    OP_LOOKUP       = 2'd3
  } opcode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // latch a new input beat
    logic scan;      // walk the live entries
    logic store;     // write the key into the ring
    logic load_out;  // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;  // the walk has finished this cycle
    logic store_req;  // check-and-insert missed, so the key must be stored
  } sts_t;

endpackage

### rtl/adf_ctrl.sv
// Controller state machine of the aging duplicate filter.
module adf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      opcode_i,
  input  logic            out_stall_i,
  input  adf_pkg::sts_t   sts_i,
  output adf_pkg::cmd_t   cmd_o,
  output logic            in_stall_o,
  output logic            out_valid_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_STORE = 4'b0100,
    S_FIN   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // The result register can take a new beat when empty or being emptied.
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (adf_pkg::opcode_e'(opcode_i) == adf_pkg::OP_INSERT) begin
            state_d = S_STORE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = sts_i.store_req ? S_STORE : S_FIN;
        end
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid flag of the result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### rtl/adf_datapath.sv
// Datapath of the aging duplicate filter: entry ring, pointers, timer and result.
module adf_datapath #(
  parameter int unsigned LIST_DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  adf_pkg::cmd_t                cmd_i,
  output adf_pkg::sts_t                sts_o,
  input  logic [1:0]                   opcode_i,
  input  logic [adf_pkg::KeyW-1:0]     key_i,
  input  logic                         cfg_we_i,
  input  logic [adf_pkg::StampW-1:0]   cfg_wdata_i,
  output logic                         found_o,
  output logic [adf_pkg::OutCntW-1:0]  live_count_o
);

  localparam int unsigned IdxW  = $clog2(LIST_DEPTH);
  localparam int unsigned CntW  = $clog2(LIST_DEPTH + 1);
  localparam int unsigned SumW  = IdxW + 2;
  localparam int unsigned WordW = adf_pkg::KeyW + adf_pkg::StampW;
  localparam logic [SumW-1:0] DepthSum = SumW'(LIST_DEPTH);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(LIST_DEPTH - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(LIST_DEPTH);

  // Entry ring: key in the upper half, stamp in the lower half.
  logic [WordW-1:0] mem_q [LIST_DEPTH];
  logic [WordW-1:0] rdata_q;
  logic             rvld_q, rvld_d;

  adf_pkg::opcode_e              op_q;
  logic [adf_pkg::KeyW-1:0]      key_q;
  logic [adf_pkg::StampW-1:0]    tick_q, tick_d;
  logic [adf_pkg::StampW-1:0]    max_age_q;
  logic [IdxW-1:0]               widx_q, widx_d;
  logic [IdxW-1:0]               pos_q, pos_d;
  logic [CntW-1:0]               live_q, live_d;
  logic [CntW-1:0]               rem_q, rem_d;
  logic                          found_q, found_d;
  logic                          found_out_q;
  logic [adf_pkg::OutCntW-1:0]   live_out_q;

  logic [SumW-1:0]               old_sum;
  logic [IdxW-1:0]               oldest;
  logic                          issue;
  logic                          is_tick;
  logic                          is_match_op;
  logic                          hit_now;
  logic                          young_now;
  logic                          expire_now;
  logic [adf_pkg::StampW-1:0]    age;
  logic [CntW+adf_pkg::OutCntW-1:0] live_ext;

  // Oldest live slot: write index minus live count, wrapped by one subtract.
  assign old_sum = SumW'(widx_q) + DepthSum - SumW'(live_q);
  always_comb begin
    if (old_sum >= DepthSum) begin
      oldest = IdxW'(old_sum - DepthSum);
    end else begin
      oldest = IdxW'(old_sum);
    end
  end

  // Compare stage on the entry read in the previous cycle.
  assign is_tick     = (op_q == adf_pkg::OP_TICK);
  assign is_match_op = (op_q == adf_pkg::OP_CHECK_INSERT) || (op_q == adf_pkg::OP_LOOKUP);
  assign age         = tick_q - rdata_q[adf_pkg::StampW-1:0];
  assign hit_now     = cmd_i.scan && rvld_q && is_match_op
                       && (rdata_q[WordW-1:adf_pkg::StampW] == key_q);
  assign expire_now  = cmd_i.scan && rvld_q && is_tick && (age > max_age_q);
  assign young_now   = cmd_i.scan && rvld_q && is_tick && !(age > max_age_q);
  assign issue       = cmd_i.scan && (rem_q != '0);

  assign sts_o.scan_done = hit_now || young_now || (rem_q == '0 && !rvld_q);
  assign sts_o.store_req = (op_q == adf_pkg::OP_CHECK_INSERT) && !found_q && !hit_now;

  // Next values of the control registers.
  always_comb begin
    tick_d  = tick_q;
    widx_d  = widx_q;
    pos_d   = pos_q;
    live_d  = live_q;
    rem_d   = rem_q;
    rvld_d  = rvld_q;
    found_d = found_q;
    if (cmd_i.accept) begin
      if (adf_pkg::opcode_e'(opcode_i) == adf_pkg::OP_TICK) begin
        tick_d = tick_q + 1'b1;
      end
      pos_d   = oldest;
      rem_d   = live_q;
      rvld_d  = 1'b0;
      found_d = 1'b0;
    end
    if (cmd_i.scan) begin
      rvld_d = issue;
      if (issue) begin
        pos_d = (pos_q == LastIdx) ? '0 : pos_q + 1'b1;
        rem_d = rem_q - 1'b1;
      end
      if (hit_now) begin
        found_d = 1'b1;
      end
      if (expire_now) begin
        live_d = live_q - 1'b1;
      end
    end
    if (cmd_i.store) begin
      widx_d = (widx_q == LastIdx) ? '0 : widx_q + 1'b1;
      if (live_q != DepthCnt) begin
        live_d = live_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q    <= '0;
      widx_q    <= '0;
      live_q    <= '0;
      pos_q     <= '0;
      rem_q     <= '0;
      rvld_q    <= 1'b0;
      found_q   <= 1'b0;
      max_age_q <= adf_pkg::MaxAgeReset;
    end else begin
      tick_q  <= tick_d;
      widx_q  <= widx_d;
      live_q  <= live_d;
      pos_q   <= pos_d;
      rem_q   <= rem_d;
      rvld_q  <= rvld_d;
      found_q <= found_d;
      if (cfg_we_i) begin
        max_age_q <= cfg_wdata_i;
      end
    end
  end

  // Input beat payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= adf_pkg::opcode_e'(opcode_i);
      key_q <= key_i;
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem_q[widx_q] <= {key_q, tick_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rdata_q <= mem_q[pos_q];
    end
  end

  // Result register.
  assign live_ext = {{adf_pkg::OutCntW{1'b0}}, live_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      found_out_q <= found_q;
      live_out_q  <= live_ext[adf_pkg::OutCntW-1:0];
    end
  end

  assign found_o      = found_out_q;
  assign live_count_o = live_out_q;

endmodule

### rtl/aging_duplicate_filter.sv
// Top level of the aging duplicate filter: controller, datapath and checks.
//
// The filter keeps a ring of LIST_DEPTH recently heard 16-bit packet hashes,
// each stamped with a 16-bit tick counter, and answers one opcode per input
// beat with one result beat (found, live_count). Items are handled one at a
// time: inserts store the key without a walk; lookups and ageing walk the
// ring through the single read port of the entry memory, one entry a cycle.
// A finished result sits in an output register, so the next item is taken
// while that result waits. The max_age register is written through the
// configuration channel, which is always ready; write it only while idle.
// Ring entries need no clearing after reset.
module aging_duplicate_filter #(
  parameter int unsigned LIST_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] key_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [4:0]  live_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_wdata_i
);

`include "aging_duplicate_filter_macros.svh"

  adf_pkg::cmd_t cmd;
  adf_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Sequencer.
  adf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .opcode_i    (opcode_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  // Ring, pointers, timer and result register.
  adf_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .opcode_i     (opcode_i),
    .key_i        (key_i),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_wdata_i  (cfg_wdata_i),
    .found_o      (found_o),
    .live_count_o (live_count_o)
  );

  // An accepted beat keeps the block busy in the following cycle.
  `ADF_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "block not busy after accept")

  // A waiting result is never overwritten.
  `ADF_ASSERT_NOW(a_no_result_overwrite, cmd.load_out, !out_valid_o || !out_stall_i, "result overwritten")

  // The controller issues at most one command per cycle.
  `ADF_ASSERT_NOW(a_single_command, 1'b1, $onehot0({cmd.accept, cmd.scan, cmd.store, cmd.load_out}), "several commands at once")

endmodule
